### design/tlcs_pkg.sv
// Shared types and constants for the text line column slicer.
// No dependencies; imported by every module of the block.
`default_nettype none
package tlcs_pkg;

  localparam int TAB_WIDTH = 8;
  localparam int CNT_W     = $clog2(TAB_WIDTH + 1);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [CNT_W-1:0] TAB_W_C = CNT_W'(TAB_WIDTH);

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic REG_FIRST_COLUMN = 1'b0;
  localparam logic REG_WINDOW_WIDTH = 1'b1;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } esc_mode_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
    logic       empty_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        is_terminator;
    logic [15:0] emitted_count;
    logic        run_last;
  } out_item_t;

  // One queued job: ch repeated rep times, then an optional terminator.
  typedef struct packed {
    logic [7:0]       ch;
    logic [CNT_W-1:0] rep;
    logic             term;
    logic [15:0]      count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

### design/tlcs_front.sv
// Front end: classifies each input byte, tracks escape/column/count state.
// Depends on tlcs_pkg; feeds jobs to tlcs_queue.
`default_nettype none
module tlcs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire tlcs_pkg::in_item_t item,
  input  wire logic [15:0]      first_column,
  input  wire logic [15:0]      window_width,
  output logic                  push,
  output tlcs_pkg::job_t        job
);
  import tlcs_pkg::*;

  esc_mode_t        mode_r, mode_nxt;
  logic [16:0]      col_r, col_nxt;
  logic [CNT_W-1:0] phase_r, phase_nxt;
  logic [15:0]      bytes_r, bytes_nxt;

  logic [16:0]      end_col;
  logic [16:0]      first_ext;
  logic             active;
  logic [7:0]       c;
  logic [CNT_W-1:0] rep;
  logic [16:0]      tab_end;
  logic [16:0]      tab_from;
  logic [16:0]      tab_to;
  logic [16:0]      tab_span;
  logic [16:0]      tab_adv;
  logic [16:0]      bsum;
  logic [15:0]      bytes_upd;
  logic             term;

  always_comb begin
    first_ext = {1'b0, first_column};
    end_col   = first_ext + {1'b0, window_width};
    active    = (window_width != 16'd0) && (col_r < end_col);
    c         = item.line_byte;
    tab_end   = col_r + 17'(TAB_W_C - phase_r);
    tab_from  = (col_r > first_ext) ? col_r : first_ext;
    tab_to    = (tab_end < end_col) ? tab_end : end_col;
    tab_span  = tab_to - tab_from;
    tab_adv   = tab_to - col_r;
  end

  always_comb begin
    mode_nxt  = mode_r;
    col_nxt   = col_r;
    phase_nxt = phase_r;
    rep       = '0;
    if (!item.empty_line && active) begin
      if (mode_r == MODE_CSI) begin
        rep = CNT_W'(1);
        if (c >= CH_AT && c <= CH_TILDE) mode_nxt = MODE_TEXT;
      end else if (mode_r == MODE_ESC && c == CH_LBRK) begin
        rep      = CNT_W'(1);
        mode_nxt = MODE_CSI;
      end else begin
        // ESC followed by anything but '[' falls back to plain text handling
        mode_nxt = MODE_TEXT;
        if (c == CH_ESC) begin
          rep      = CNT_W'(1);
          mode_nxt = MODE_ESC;
        end else if (c == CH_TAB) begin
          if (tab_to > tab_from) rep = tab_span[CNT_W-1:0];
          col_nxt   = tab_to;
          // clipped at the window end: phase follows the column, a wider window may follow
          phase_nxt = (tab_to == tab_end) ? '0 : phase_r + tab_adv[CNT_W-1:0];
        end else if (c < CH_SPACE || c == CH_DEL) begin
          rep = '0;
        end else begin
          if (col_r >= first_ext) rep = CNT_W'(1);
          col_nxt   = col_r + 17'd1;
          phase_nxt = (phase_r == TAB_W_C - CNT_W'(1)) ? '0 : phase_r + CNT_W'(1);
        end
      end
    end
    bsum      = {1'b0, bytes_r} + 17'(rep);
    bytes_upd = bsum[16] ? 16'hffff : bsum[15:0];
    bytes_nxt = bytes_upd;
    term      = item.empty_line || item.line_end;
    if (term) begin
      mode_nxt  = MODE_TEXT;
      col_nxt   = '0;
      phase_nxt = '0;
      bytes_nxt = '0;
    end
  end

  always_comb begin
    push      = accept && (term || rep != '0);
    // a tab inside a CSI sequence passes through as is
    job.ch    = (c == CH_TAB && mode_r != MODE_CSI) ? CH_SPACE : c;
    job.rep   = rep;
    job.term  = term;
    job.count = bytes_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      col_r   <= '0;
      phase_r <= '0;
      bytes_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      bytes_r <= bytes_nxt;
    end
  end

endmodule
`default_nettype wire

### design/tlcs_queue.sv
// Short job queue between front and back, register based.
// Depends on tlcs_pkg.
`default_nettype none
module tlcs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tlcs_pkg::job_t push_job,
  input  wire logic           pop,
  output tlcs_pkg::job_t      head,
  output tlcs_pkg::q_stat_t   stat
);
  import tlcs_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt;
  logic [Q_PTR_W-1:0] rp_r, rp_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + Q_PTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + Q_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    head    = mem_r[rp_r];
    stat.full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
    stat.empty = (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

### design/tlcs_back.sv
// Back end: expands queued jobs into result beats through an output register.
// Depends on tlcs_pkg; drains tlcs_queue.
`default_nettype none
module tlcs_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tlcs_pkg::job_t    head,
  input  wire tlcs_pkg::q_stat_t stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tlcs_pkg::out_item_t    out_beat
);
  import tlcs_pkg::*;

  logic             valid_r, valid_nxt;
  out_item_t        data_r, data_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             load;
  logic             last_char;

  always_comb begin
    load      = !valid_r || out_ready;
    last_char = (idx_r + CNT_W'(1) == head.rep);
    valid_nxt = valid_r;
    data_nxt  = data_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !stat.empty;
      if (!stat.empty) begin
        if (idx_r < head.rep) begin
          data_nxt.out_char      = head.ch;
          data_nxt.is_terminator = 1'b0;
          data_nxt.emitted_count = '0;
          data_nxt.run_last      = last_char && !head.term;
          pop                    = last_char && !head.term;
          idx_nxt                = pop ? '0 : idx_r + CNT_W'(1);
        end else begin
          data_nxt.out_char      = '0;
          data_nxt.is_terminator = 1'b1;
          data_nxt.emitted_count = head.count;
          data_nxt.run_last      = 1'b1;
          pop                    = 1'b1;
          idx_nxt                = '0;
        end
      end
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && data_r.is_terminator |-> data_r.run_last && data_r.out_char == 8'd0)
    else $error("terminator beat malformed");
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.empty |-> (idx_r < head.rep) || head.term)
    else $error("expansion index ran past job");
  a_idx_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> idx_r == '0)
    else $error("expansion index left over with empty queue");
`endif

endmodule
`default_nettype wire

### design/text_line_column_slicer_top.sv
// Top level of the text line column slicer: config registers, front, queue, back.
// Depends on tlcs_pkg, tlcs_front, tlcs_queue, tlcs_back.
//
//   channel | handshake          | payload
//   in      | in_valid/in_ready  | in_data   (line_byte, line_end, empty_line)
//   out     | out_valid/out_ready| out_beat  (out_char, is_terminator, emitted_count, run_last)
//   cfg     | psel/penable/pwrite| paddr[2:0], pwdata, prdata (first_column, window_width)
//
// An input byte is accepted every cycle while the 4-entry job queue has room.
// The back end emits one result beat per cycle while jobs are queued and out_ready is high;
// a tab expands into up to TAB_WIDTH beats there, and the terminator adds one more, so the queue fills during tab runs.
// Items that produce no result are handled in the front end only.
// Reset is synchronous, active low; no clearing pass.
`default_nettype none
module text_line_column_slicer_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlcs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tlcs_pkg::out_item_t      out_beat,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import tlcs_pkg::*;

  logic [15:0] first_col_r;
  logic [15:0] win_width_r;
  logic        cfg_wr;
  logic        accept;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head;
  q_stat_t     stat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (paddr[2])
      REG_FIRST_COLUMN: prdata = {16'd0, first_col_r};
      REG_WINDOW_WIDTH: prdata = {16'd0, win_width_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_col_r <= 16'd0;
      win_width_r <= 16'd80;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIRST_COLUMN) first_col_r <= pwdata[15:0];
      if (paddr[2] == REG_WINDOW_WIDTH) win_width_r <= pwdata[15:0];
    end
  end

  tlcs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .item         (in_data),
    .first_column (first_col_r),
    .window_width (win_width_r),
    .push         (push),
    .job          (push_job)
  );

  tlcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  tlcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

### tb/text_line_column_slicer_top_tb.sv
// Testbench for text_line_column_slicer_top: scoreboard class, valid/ready drivers, APB writes.
// Depends on tlcs_pkg and the text_line_column_slicer_top RTL.
`default_nettype none
module text_line_column_slicer_top_tb;
  import tlcs_pkg::*;

  localparam int LIMIT       = 1_500_000;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int END_WAIT    = 20_000;
  localparam int MAX_PRINT   = 40;
  localparam int NUM_PHASES  = 9;

  class column_slicer_scoreboard;
    logic [15:0] first_col;
    logic [15:0] win_width;
    esc_mode_t   mode;
    logic [16:0] column;
    logic [15:0] n_emitted;
    out_item_t   pending_q[$];
    int          errors;
    int          n_beats;

    function new();
      first_col = 16'd0;
      win_width = 16'd80;
      errors    = 0;
      n_beats   = 0;
      clear_line();
    endfunction

    function void clear_line();
      mode      = MODE_TEXT;
      column    = 17'd0;
      n_emitted = 16'd0;
    endfunction

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == REG_FIRST_COLUMN) first_col = value;
      else win_width = value;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void push_beat(logic [7:0] ch, logic term, logic [15:0] cnt);
      out_item_t r;
      r.out_char      = ch;
      r.is_terminator = term;
      r.emitted_count = cnt;
      r.run_last      = 1'b0;
      pending_q.push_back(r);
    endfunction

    function void emit_char(logic [7:0] ch);
      push_beat(ch, 1'b0, 16'd0);
      if (n_emitted != 16'hffff) n_emitted++;
    endfunction

    function void slice_byte(logic [7:0] c);
      int end_col, span, tab_end, from, to;
      end_col = int'(first_col) + int'(win_width);
      if (win_width == 16'd0 || int'(column) >= end_col) return;
      if (mode == MODE_CSI) begin
        emit_char(c);
        if (c >= CH_AT && c <= CH_TILDE) mode = MODE_TEXT;
        return;
      end
      if (mode == MODE_ESC) begin
        mode = MODE_TEXT;
        if (c == CH_LBRK) begin
          emit_char(c);
          mode = MODE_CSI;
          return;
        end
      end
      if (c == CH_ESC) begin
        emit_char(c);
        mode = MODE_ESC;
        return;
      end
      if (c == CH_TAB) begin
        span    = TAB_WIDTH - (int'(column) % TAB_WIDTH);
        tab_end = int'(column) + span;
        from    = (int'(column) > int'(first_col)) ? int'(column) : int'(first_col);
        to      = (tab_end < end_col) ? tab_end : end_col;
        for (int k = from; k < to; k++) emit_char(CH_SPACE);
        column = 17'(to);
        return;
      end
      if (c < CH_SPACE || c == CH_DEL) return;
      if (column >= first_col) emit_char(c);
      column++;
    endfunction

    function void note_input(in_item_t it);
      int        n_before;
      out_item_t r;
      n_before = pending_q.size();
      if (!it.empty_line) slice_byte(it.line_byte);
      if (it.empty_line || it.line_end) begin
        push_beat(8'h00, 1'b1, n_emitted);
        clear_line();
      end
      if (pending_q.size() > n_before) begin
        r = pending_q.pop_back();
        r.run_last = 1'b1;
        pending_q.push_back(r);
      end
    endfunction

    task report(string msg);
      // keep the log short on a systematic failure; every mismatch still counts
      if (errors < MAX_PRINT) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got 0x%0h, want 0x%0h", n_beats, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected: %p", n_beats, got));
      end else begin
        want = pending_q.pop_front();
        check_field("out_char", 16'(got.out_char), 16'(want.out_char));
        check_field("is_terminator", 16'(got.is_terminator), 16'(want.is_terminator));
        check_field("emitted_count", got.emitted_count, want.emitted_count);
        check_field("run_last", 16'(got.run_last), 16'(want.run_last));
      end
      n_beats++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_beat;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  column_slicer_scoreboard sb = new();

  bit       hold_req;
  bit       in_idle_on;
  bit       out_idle_on;
  bit       quiet;
  int       items_sent;
  int       cycle_count;
  in_item_t line_buf[$];

  text_line_column_slicer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** text_line_column_slicer_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_beat);
  end

  function automatic int pick_gap(bit short_only);
    if (short_only || $urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && out_idle_on && $urandom_range(0, 99) < 15) begin
        stall = pick_gap(quiet);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t mk_item(logic [7:0] b, logic last, logic empty);
    in_item_t it;
    it.line_byte  = b;
    it.line_end   = last;
    it.empty_line = empty;
    return it;
  endfunction

  // optional idle gap first, then the beat is held until accepted
  task automatic send_item(in_item_t it);
    int gap;
    if (in_idle_on && $urandom_range(0, 99) < 20) begin
      gap = pick_gap(quiet);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // beats that cause no result may still sit in the front end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_window(logic [15:0] first, logic [15:0] width);
    cfg_write(REG_FIRST_COLUMN, first);
    cfg_write(REG_WINDOW_WIDTH, width);
  endtask

  function automatic void add_byte(logic [7:0] b);
    line_buf.push_back(mk_item(b, 1'b0, 1'b0));
  endfunction

  function automatic void add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      add_byte(8'($urandom_range(32, 126)));
    end else if (r < 65) begin
      add_byte(CH_TAB);
    end else if (r < 78) begin
      add_byte(CH_ESC);
      add_byte(CH_LBRK);
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(32, 63)));
      add_byte(8'($urandom_range(64, 126)));
    end else if (r < 85) begin
      // lone escape: the next byte is ordinary text
      add_byte(CH_ESC);
      add_byte(8'($urandom_range(32, 90)));
    end else if (r < 92) begin
      add_byte(($urandom_range(0, 7) == 0) ? CH_DEL : 8'($urandom_range(0, 31)));
    end else begin
      add_byte(8'($urandom_range(128, 255)));
    end
  endfunction

  task automatic send_line(bit well_formed);
    int       len;
    in_item_t it;
    line_buf.delete();
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    repeat (len) begin
      if (well_formed) add_token();
      else add_byte(8'($urandom_range(0, 255)));
    end
    if (line_buf.size() == 0 || $urandom_range(0, 9) == 0) begin
      // empty-line beat: byte and line_end are don't-care
      line_buf.push_back(mk_item(8'($urandom), 1'($urandom), 1'b1));
    end else begin
      it = line_buf.pop_back();
      it.line_end = 1'b1;
      line_buf.push_back(it);
    end
    foreach (line_buf[i]) send_item(line_buf[i]);
  endtask

  int ph_first[NUM_PHASES] = '{0, 2, 0, 7, 65535, 0, 0, 0, 5};
  int ph_width[NUM_PHASES] = '{80, 10, 1, 3, 65535, 65535, 0, 0, 20};
  int ph_items[NUM_PHASES] = '{50, 40, 35, 45, 35, 50, 50, 20, 55};

  initial begin : stimulus
    int start_cnt, w;
    logic [15:0] f, wd;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    quiet       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window, empty line, byte extremes, escapes, line ending in CSI
    send_item(mk_item(8'hff, 1'b1, 1'b1));
    send_item(mk_item(8'h20, 1'b0, 1'b0));
    send_item(mk_item(8'h7e, 1'b0, 1'b0));
    send_item(mk_item(8'h80, 1'b0, 1'b0));
    send_item(mk_item(8'hff, 1'b0, 1'b0));
    send_item(mk_item(8'h00, 1'b0, 1'b0));
    send_item(mk_item(8'h1f, 1'b0, 1'b0));
    send_item(mk_item(CH_DEL, 1'b0, 1'b0));
    send_item(mk_item(CH_TAB, 1'b0, 1'b0));
    send_item(mk_item(CH_ESC, 1'b0, 1'b0));
    send_item(mk_item(CH_LBRK, 1'b0, 1'b0));
    send_item(mk_item("3", 1'b0, 1'b0));
    send_item(mk_item("m", 1'b0, 1'b0));
    send_item(mk_item(CH_ESC, 1'b0, 1'b0));
    send_item(mk_item("X", 1'b0, 1'b0));
    send_item(mk_item(CH_ESC, 1'b0, 1'b0));
    send_item(mk_item(CH_ESC, 1'b0, 1'b0));
    send_item(mk_item(CH_LBRK, 1'b1, 1'b0));

    // narrow window: a tab that ends at the window end, then everything past it is dropped
    drain_results();
    set_window(16'd3, 16'd5);
    send_item(mk_item("a", 1'b0, 1'b0));
    send_item(mk_item("b", 1'b0, 1'b0));
    send_item(mk_item("c", 1'b0, 1'b0));
    send_item(mk_item("d", 1'b0, 1'b0));
    send_item(mk_item(CH_TAB, 1'b0, 1'b0));
    send_item(mk_item("x", 1'b0, 1'b0));
    send_item(mk_item(CH_ESC, 1'b1, 1'b0));

    // zero width: escapes dropped too, terminator only
    drain_results();
    cfg_write(REG_WINDOW_WIDTH, 16'd0);
    send_item(mk_item("q", 1'b0, 1'b0));
    send_item(mk_item(CH_ESC, 1'b0, 1'b0));
    send_item(mk_item(CH_TAB, 1'b1, 1'b0));

    // register change in the middle of a line
    drain_results();
    set_window(16'd0, 16'd80);
    send_item(mk_item("a", 1'b0, 1'b0));
    send_item(mk_item(CH_TAB, 1'b0, 1'b0));
    drain_results();
    cfg_write(REG_FIRST_COLUMN, 16'd2);
    send_item(mk_item("b", 1'b0, 1'b0));
    send_item(mk_item("c", 1'b1, 1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      f  = 16'(ph_first[p]);
      wd = 16'(ph_width[p]);
      if (p == 6) begin
        f  = 16'($urandom_range(0, 20));
        wd = 16'($urandom_range(1, 40));
      end
      set_window(f, wd);
      if (p == 5) hold_req = 1'b1;
      start_cnt = items_sent;
      while (items_sent - start_cnt < ph_items[p]) begin
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
        send_line($urandom_range(0, 99) < 75);
      end
    end

    in_valid <= 1'b0;
    for (w = 0; w < END_WAIT && sb.pending() != 0; w++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("** text_line_column_slicer_top: PASSED **");
    end else begin
      $display("** text_line_column_slicer_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
